FILE: hw/rtl/acsd_pkg.sv
// Package for the assignment cost and swap delta evaluator.
// Holds the request and result structs, request and state codes and fixed widths.
// Has no dependencies; the top level and the MAC pipeline use it, the RAM does not.
`default_nettype none

package acsd_pkg;

  // Fixed field widths of the request and result transfers.
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned RES_W     = 48;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  // Count width that covers the largest zone or location count supported.
  localparam int unsigned CNT_W     = 9;

  localparam logic [CFG_W-1:0] ZONE_CFG_RST = 7'd64;
  localparam logic [CFG_W-1:0] LOC_CFG_RST  = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_FLOW  = 3'd0,
    REQ_LOAD_DIST  = 3'd1,
    REQ_LOAD_ASG   = 3'd2,
    REQ_FULL_COST  = 3'd3,
    REQ_SWAP_DELTA = 3'd4,
    REQ_APPLY_SWAP = 3'd5
  } acsd_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_COUNT = 1'b0,
    CFG_LOC_COUNT  = 1'b1
  } acsd_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCS,
    ST_RUN,
    ST_DRAIN,
    ST_XCHG_I,
    ST_XCHG_J
  } acsd_state_e;

  // Kind of one memory read beat entering the arithmetic pipeline.
  typedef enum logic [1:0] {
    BEAT_NONE,
    BEAT_COST,
    BEAT_SWAP_P,
    BEAT_SWAP_Q
  } acsd_beat_e;

  typedef struct packed {
    acsd_beat_e kind;
    logic       live;
  } acsd_beat_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic [VAL_W-1:0] load_value;
  } acsd_req_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic                    status;
  } acsd_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/assignment_cost_and_swap_delta.sv
// Quadratic assignment evaluator: loads, full cost, swap saving and swap apply.
// Loads and rejected requests give their result in the cycle after acceptance; apply swap
// passes through its two exchange states first. Full cost issues one flow memory read beat
// per zone pair of the zone count in use, swap delta two per zone; both then drain the pipeline.
// One request at a time; results are strobed for one cycle and cannot be stalled.
// Reset clears control state and sets the count registers to 64; the memories are not cleared.
`default_nettype none

module assignment_cost_and_swap_delta #(
  parameter int unsigned MAX_ZONES     = 64,
  parameter int unsigned MAX_LOCATIONS = 64,
  parameter int unsigned ENTRY_BITS    = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire acsd_pkg::acsd_req_t               req_i,
  output logic                                   done_o,
  output acsd_pkg::acsd_res_t                    res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [acsd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [acsd_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned ZW  = $clog2(MAX_ZONES);
  localparam int unsigned LW  = $clog2(MAX_LOCATIONS);
  localparam int unsigned EB  = ENTRY_BITS;
  localparam int unsigned CW  = acsd_pkg::CNT_W;
  localparam int unsigned IW  = acsd_pkg::IDX_W;

  acsd_pkg::acsd_state_e state_q, state_d;
  logic [acsd_pkg::CFG_W-1:0] zone_cfg_q, loc_cfg_q;
  logic [CW-1:0]  zsat, lsat, zc, lc;
  logic [ZW-1:0]  zlast;
  logic [ZW-1:0]  a_q, a_d, b_q, b_d;
  logic           ph_q, ph_d;
  logic           op_cost_q, op_cost_d;
  logic [IW-1:0]  i_q, i_d, j_q, j_d;
  logic           both_q, both_d;
  logic [LW-1:0]  li_q, li_d, lj_q, lj_d, tmp_q, tmp_d;
  logic           done_q, done_d;
  acsd_pkg::acsd_res_t res_q, res_d;
  logic [CW-1:0]  i9, j9;

  logic              fl_we;
  logic [2*ZW-1:0]   fl_waddr, fl_ra0, fl_ra1;
  logic [EB-1:0]     fl_wdata, fl_rd0, fl_rd1;
  logic              ds_we;
  logic [2*LW-1:0]   ds_waddr, ds_ra0, ds_ra1;
  logic [EB-1:0]     ds_wdata, ds_rd0, ds_rd1;
  logic              as_we;
  logic [LW-1:0]     as_waddr, as_wdata, as_ra0, as_ra1, as_rd0, as_rd1;

  acsd_pkg::acsd_beat_t beat;
  logic                 mac_clr;
  logic                 mac_busy;
  logic [acsd_pkg::RES_W-1:0] acc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_cfg_q <= acsd_pkg::ZONE_CFG_RST;
      loc_cfg_q  <= acsd_pkg::LOC_CFG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acsd_pkg::CFG_ZONE_COUNT: zone_cfg_q <= cfg_wdata_i;
        acsd_pkg::CFG_LOC_COUNT:  loc_cfg_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Counts in use: saturated to the supported range, zones limited to locations.
  always_comb begin
    lsat = CW'(loc_cfg_q);
    if (lsat == '0) begin
      lsat = CW'(1);
    end else if (lsat > CW'(MAX_LOCATIONS)) begin
      lsat = CW'(MAX_LOCATIONS);
    end
    zsat = CW'(zone_cfg_q);
    if (zsat == '0) begin
      zsat = CW'(1);
    end else if (zsat > CW'(MAX_ZONES)) begin
      zsat = CW'(MAX_ZONES);
    end
    lc = lsat;
    zc = (zsat > lsat) ? lsat : zsat;
  end

  assign zlast = ZW'(zc - CW'(1));
  assign i9    = CW'(req_i.first_index);
  assign j9    = CW'(req_i.second_index);

  // Distance reads follow the assignment read data of the previous cycle.
  assign ds_ra0 = op_cost_q ? {as_rd0, as_rd1} : {as_rd1, li_q};
  assign ds_ra1 = {as_rd1, lj_q};

  assign busy_o = (state_q != acsd_pkg::ST_IDLE);

  // Request decode, read beat sequencing and result formation.
  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    ph_d      = ph_q;
    op_cost_d = op_cost_q;
    i_d       = i_q;
    j_d       = j_q;
    both_d    = both_q;
    li_d      = li_q;
    lj_d      = lj_q;
    tmp_d     = tmp_q;
    done_d    = 1'b0;
    res_d     = '0;
    mac_clr   = 1'b0;
    beat      = '{kind: acsd_pkg::BEAT_NONE, live: 1'b0};
    fl_we     = 1'b0;
    fl_waddr  = {ZW'(req_i.first_index), ZW'(req_i.second_index)};
    fl_wdata  = EB'(req_i.load_value);
    ds_we     = 1'b0;
    ds_waddr  = {LW'(req_i.first_index), LW'(req_i.second_index)};
    ds_wdata  = EB'(req_i.load_value);
    as_we     = 1'b0;
    as_waddr  = LW'(req_i.first_index);
    as_wdata  = LW'(req_i.load_value - acsd_pkg::VAL_W'(1));
    fl_ra0    = {a_q, b_q};
    fl_ra1    = {b_q, a_q};
    as_ra0    = LW'(req_i.first_index);
    as_ra1    = LW'(req_i.second_index);

    case (state_q)
      acsd_pkg::ST_IDLE: begin
        if (start_i) begin
          case (req_i.req_type)
            acsd_pkg::REQ_LOAD_FLOW: begin
              done_d = 1'b1;
              if (i9 < zc && j9 < zc) begin
                fl_we = 1'b1;
              end else begin
                res_d.status = 1'b1;
              end
            end
            acsd_pkg::REQ_LOAD_DIST: begin
              done_d = 1'b1;
              if (i9 < lc && j9 < lc) begin
                ds_we = 1'b1;
              end else begin
                res_d.status = 1'b1;
              end
            end
            acsd_pkg::REQ_LOAD_ASG: begin
              done_d = 1'b1;
              if (i9 < lc && req_i.load_value != '0 &&
                  req_i.load_value <= acsd_pkg::VAL_W'(lc)) begin
                as_we = 1'b1;
              end else begin
                res_d.status = 1'b1;
              end
            end
            acsd_pkg::REQ_FULL_COST: begin
              mac_clr   = 1'b1;
              op_cost_d = 1'b1;
              a_d       = '0;
              b_d       = '0;
              state_d   = acsd_pkg::ST_RUN;
            end
            acsd_pkg::REQ_SWAP_DELTA: begin
              if (i9 < j9 && i9 < zc && j9 < lc) begin
                mac_clr   = 1'b1;
                op_cost_d = 1'b0;
                i_d       = req_i.first_index;
                j_d       = req_i.second_index;
                both_d    = (j9 < zc);
                b_d       = '0;
                ph_d      = 1'b0;
                state_d   = acsd_pkg::ST_LOCS;
              end else begin
                done_d       = 1'b1;
                res_d.status = 1'b1;
              end
            end
            acsd_pkg::REQ_APPLY_SWAP: begin
              if (i9 < lc && j9 < lc) begin
                i_d     = req_i.first_index;
                j_d     = req_i.second_index;
                state_d = acsd_pkg::ST_XCHG_I;
              end else begin
                done_d       = 1'b1;
                res_d.status = 1'b1;
              end
            end
            default: begin
              done_d       = 1'b1;
              res_d.status = 1'b1;
            end
          endcase
        end
      end

      // Locations of the two swapped positions, read at acceptance.
      acsd_pkg::ST_LOCS: begin
        li_d    = as_rd0;
        lj_d    = as_rd1;
        state_d = acsd_pkg::ST_RUN;
      end

      acsd_pkg::ST_RUN: begin
        if (op_cost_q) begin
          // One zone pair per cycle, row by row.
          beat   = '{kind: acsd_pkg::BEAT_COST, live: 1'b1};
          as_ra0 = LW'(a_q);
          as_ra1 = LW'(b_q);
          if (b_q == zlast) begin
            b_d = '0;
            if (a_q == zlast) begin
              state_d = acsd_pkg::ST_DRAIN;
            end else begin
              a_d = a_q + 1'b1;
            end
          end else begin
            b_d = b_q + 1'b1;
          end
        end else begin
          // Two beats per zone k: flows with position i, then with position j.
          as_ra1    = LW'(b_q);
          beat.live = !((CW'(b_q) == CW'(i_q)) || (both_q && CW'(b_q) == CW'(j_q)));
          if (!ph_q) begin
            beat.kind = acsd_pkg::BEAT_SWAP_P;
            fl_ra0    = {ZW'(i_q), b_q};
            fl_ra1    = {b_q, ZW'(i_q)};
            ph_d      = 1'b1;
          end else begin
            beat.kind = acsd_pkg::BEAT_SWAP_Q;
            fl_ra0    = {ZW'(j_q), b_q};
            fl_ra1    = {b_q, ZW'(j_q)};
            ph_d      = 1'b0;
            if (b_q == zlast) begin
              state_d = acsd_pkg::ST_DRAIN;
            end else begin
              b_d = b_q + 1'b1;
            end
          end
        end
      end

      // Wait for the last product to reach the accumulator.
      acsd_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          done_d             = 1'b1;
          res_d.result_value = $signed(acc);
          state_d            = acsd_pkg::ST_IDLE;
        end
      end

      // Exchange the two assignment entries in two write states, position i first, then j.
      acsd_pkg::ST_XCHG_I: begin
        as_we    = 1'b1;
        as_waddr = LW'(i_q);
        as_wdata = as_rd1;
        tmp_d    = as_rd0;
        state_d  = acsd_pkg::ST_XCHG_J;
      end

      acsd_pkg::ST_XCHG_J: begin
        as_we    = 1'b1;
        as_waddr = LW'(j_q);
        as_wdata = tmp_q;
        done_d   = 1'b1;
        state_d  = acsd_pkg::ST_IDLE;
      end

      default: begin
        state_d = acsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acsd_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Request context and result registers.
  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    ph_q      <= ph_d;
    op_cost_q <= op_cost_d;
    i_q       <= i_d;
    j_q       <= j_d;
    both_q    <= both_d;
    li_q      <= li_d;
    lj_q      <= lj_d;
    tmp_q     <= tmp_d;
    res_q     <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Flow matrix, row-major by zone.
  acsd_ram #(
    .ADDR_W (2 * ZW),
    .DATA_W (EB)
  ) u_flow (
    .clk_i    (clk_i),
    .we_i     (fl_we),
    .waddr_i  (fl_waddr),
    .wdata_i  (fl_wdata),
    .raddr0_i (fl_ra0),
    .raddr1_i (fl_ra1),
    .rdata0_o (fl_rd0),
    .rdata1_o (fl_rd1)
  );

  // Distance matrix, row-major by location.
  acsd_ram #(
    .ADDR_W (2 * LW),
    .DATA_W (EB)
  ) u_dist (
    .clk_i    (clk_i),
    .we_i     (ds_we),
    .waddr_i  (ds_waddr),
    .wdata_i  (ds_wdata),
    .raddr0_i (ds_ra0),
    .raddr1_i (ds_ra1),
    .rdata0_o (ds_rd0),
    .rdata1_o (ds_rd1)
  );

  // Position to zero-based location table.
  acsd_ram #(
    .ADDR_W (LW),
    .DATA_W (LW)
  ) u_asg (
    .clk_i    (clk_i),
    .we_i     (as_we),
    .waddr_i  (as_waddr),
    .wdata_i  (as_wdata),
    .raddr0_i (as_ra0),
    .raddr1_i (as_ra1),
    .rdata0_o (as_rd0),
    .rdata1_o (as_rd1)
  );

  acsd_mac #(
    .ENTRY_BITS (EB)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .clr_i   (mac_clr),
    .both_i  (both_q),
    .flow0_i (fl_rd0),
    .flow1_i (fl_rd1),
    .dist0_i (ds_rd0),
    .dist1_i (ds_rd1),
    .busy_o  (mac_busy),
    .acc_o   (acc)
  );

`ifndef SYNTH
  // A result is only strobed once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobed while busy");

  // A rejected request carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status) |-> (res_o.result_value == '0))
    else $error("rejected request with nonzero value");

  // Loads finish in the cycle after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_i.req_type == acsd_pkg::REQ_LOAD_FLOW ||
     req_i.req_type == acsd_pkg::REQ_LOAD_DIST ||
     req_i.req_type == acsd_pkg::REQ_LOAD_ASG)) |=> done_o)
    else $error("load did not finish in one cycle");

  // The arithmetic pipeline is empty whenever the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acsd_pkg::ST_IDLE) |-> !mac_busy)
    else $error("pipeline busy while idle");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/acsd_ram.sv
// Simple synchronous RAM with one write port and two registered read ports.
// Used for the flow matrix, distance matrix and assignment table; uses no package items.
// Read data is registered and appears in the cycle after the address.
`default_nettype none

module acsd_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr0_i,
  input  wire logic [ADDR_W-1:0] raddr1_i,
  output logic      [DATA_W-1:0] rdata0_o,
  output logic      [DATA_W-1:0] rdata1_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/acsd_mac.sv
// Difference, multiply and accumulate pipeline of the evaluator.
// Consumes memory read data tagged by beat kind; depends on acsd_pkg.
// Stages: read data, difference terms, product, accumulator.
`default_nettype none

module acsd_mac #(
  parameter int unsigned ENTRY_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire acsd_pkg::acsd_beat_t       beat_i,
  input  wire logic                       clr_i,
  input  wire logic                       both_i,
  input  wire logic [ENTRY_BITS-1:0]      flow0_i,
  input  wire logic [ENTRY_BITS-1:0]      flow1_i,
  input  wire logic [ENTRY_BITS-1:0]      dist0_i,
  input  wire logic [ENTRY_BITS-1:0]      dist1_i,
  output logic                            busy_o,
  output logic [acsd_pkg::RES_W-1:0]      acc_o
);

  localparam int unsigned EB   = ENTRY_BITS;
  localparam int unsigned PR_W = 2 * EB + 3;

  acsd_pkg::acsd_beat_t    s1_q;
  logic                    s2_cost_q;
  logic                    dv_q;
  logic                    dv_d;
  logic                    pv_q;
  logic [EB-1:0]           f_hold_q;
  logic [EB:0]             wsum;
  logic [EB:0]             wi_q;
  logic [EB:0]             wj;
  logic signed [EB+1:0]    wdiff_d;
  logic signed [EB+1:0]    wdiff_q;
  logic signed [EB:0]      ddiff_d;
  logic signed [EB:0]      ddiff_q;
  logic signed [PR_W-1:0]  prod_q;
  logic [acsd_pkg::RES_W-1:0] acc_q;

  // Flow weight of one zone pair in both directions.
  assign wsum = {1'b0, flow0_i} + {1'b0, flow1_i};
  assign wj   = both_i ? wsum : '0;

  // Difference terms: a cost beat passes flow and distance straight through,
  // a swap beat pairs the weight difference with the distance difference.
  always_comb begin
    dv_d    = 1'b0;
    wdiff_d = $signed({2'b00, f_hold_q});
    ddiff_d = $signed({1'b0, dist0_i});
    if (s2_cost_q) begin
      dv_d = 1'b1;
    end else if (s1_q.kind == acsd_pkg::BEAT_SWAP_Q && s1_q.live) begin
      dv_d    = 1'b1;
      wdiff_d = $signed({1'b0, wi_q}) - $signed({1'b0, wj});
      ddiff_d = $signed({1'b0, dist0_i}) - $signed({1'b0, dist1_i});
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '{kind: acsd_pkg::BEAT_NONE, live: 1'b0};
      s2_cost_q <= 1'b0;
      dv_q      <= 1'b0;
      pv_q      <= 1'b0;
    end else begin
      s1_q      <= beat_i;
      s2_cost_q <= (s1_q.kind == acsd_pkg::BEAT_COST) && s1_q.live;
      dv_q      <= dv_d;
      pv_q      <= dv_q;
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    f_hold_q <= flow0_i;
    if (s1_q.kind == acsd_pkg::BEAT_SWAP_P) begin
      wi_q <= wsum;
    end
    wdiff_q <= wdiff_d;
    ddiff_q <= ddiff_d;
    prod_q  <= wdiff_q * ddiff_q;
    if (clr_i) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + acsd_pkg::RES_W'(prod_q);
    end
  end

  assign busy_o = (s1_q.kind != acsd_pkg::BEAT_NONE) || s2_cost_q || dv_q || pv_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire
